### rtl/core/dwhr_pkg.sv
package dwhr_pkg;

   // Ring buffer geometry.
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Fixed widths of the transfer fields.
   localparam int FUNC_W = 3;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 11;
   localparam int MID_W  = 10;

   typedef enum logic [FUNC_W-1:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_POP_HEAD  = 3'd1,
      OP_PUSH_TAIL = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_SWAP      = 3'd4
   } op_type;

   // One access to the element store per transfer.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_req_type;

   // Outcome of one operation, before it is registered for the result port.
   typedef struct packed {
      logic             pop_ok;
      logic             error;
      logic [CNT_W-1:0] count;
   } outcome_type;

   // Modular add of two ring positions, each already below DEPTH.
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (ADDR_W + 1)'(DEPTH)) begin
         sum = sum - (ADDR_W + 1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

### rtl/core/deque_with_half_rotate.sv
// Double-ended queue with half rotation, kept in a ring buffer memory.
// The result of a transfer accepted at a clock edge is shown on the
// rsp_ ports in the next cycle, marked by rsp_valid; busy is never raised.
// Throughput: one item per cycle, set by the single access to the element store.
// Reset clears the head index, the count and rsp_valid; the store is not cleared.
// The receiver cannot stall: every result stands on the ports for one cycle.
module deque_with_half_rotate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [dwhr_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [dwhr_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic signed [dwhr_pkg::DATA_W-1:0]  rsp_popped_value,
   output logic                                rsp_error,
   output logic [dwhr_pkg::SIZE_W-1:0]         rsp_size_now,
   output logic [dwhr_pkg::MID_W-1:0]          rsp_middle_position
);
   import dwhr_pkg::*;

   // Every operation is finished in the cycle it is accepted, so the block is
   // always ready for the next transfer.
   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   mem_req_type       mem_req;
   outcome_type       outcome;
   logic [DATA_W-1:0] rd_data;

   // The controller holds the head index and count and decides which single
   // entry of the store is written or read for this transfer.
   dwhr_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .func    (req_func),
      .value   (req_value),
      .mem_req (mem_req),
      .outcome (outcome)
   );

   // The store registers its read data, which lines up with the result register.
   dwhr_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Result register. The popped word comes straight from the store's read
   // register and is masked to zero unless a pop actually succeeded.
   logic             valid_ff;
   logic             pop_ok_ff;
   logic             error_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ok_ff <= outcome.pop_ok;
         error_ff  <= outcome.error;
         count_ff  <= outcome.count;
      end
   end

   // The middle position is count/2 + 1 in one-based terms, or zero when the
   // queue is empty.
   logic [MID_W-1:0] mid;
   always_comb begin
      if (count_ff == '0) begin
         mid = '0;
      end else begin
         mid = MID_W'(count_ff >> 1) + MID_W'(1);
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_popped_value    = pop_ok_ff ? rd_data : '0;
   assign rsp_error           = error_ff;
   assign rsp_size_now        = SIZE_W'(count_ff);
   assign rsp_middle_position = mid;

   // Every accepted transfer yields exactly one result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transfer produced no result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result without an accepted transfer");

   // A failed operation never returns a word.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_popped_value == '0))
      else $error("error result carries a popped word");

   // The count can never pass the ring depth.
   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_size_now <= SIZE_W'(DEPTH)))
      else $error("element count exceeds depth");

endmodule

### rtl/core/dwhr_ram.sv
module dwhr_ram (
   input  logic                          clock,
   input  dwhr_pkg::mem_req_type         mem_req,
   output logic [dwhr_pkg::DATA_W-1:0]   rd_data
);
   import dwhr_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dwhr_ctrl.sv
module dwhr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [dwhr_pkg::FUNC_W-1:0]   func,
   input  logic [dwhr_pkg::DATA_W-1:0]   value,
   output dwhr_pkg::mem_req_type         mem_req,
   output dwhr_pkg::outcome_type         outcome
);
   import dwhr_pkg::*;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              full, empty;
   mem_req_type       req;
   outcome_type       res;

   assign full  = (count_ff >= CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      req.wr_en  = 1'b0;
      req.rd_en  = 1'b0;
      req.addr   = head_ff;
      req.wdata  = value;
      res.pop_ok = 1'b0;
      res.error  = 1'b0;
      case (func)
         OP_PUSH_HEAD: begin
            if (full) begin
               res.error = 1'b1;
            end else begin
               head_in   = ring_add(head_ff, ADDR_W'(DEPTH - 1));
               req.addr  = head_in;
               req.wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         OP_POP_HEAD: begin
            if (empty) begin
               res.error = 1'b1;
            end else begin
               req.rd_en  = 1'b1;
               res.pop_ok = 1'b1;
               head_in    = ring_add(head_ff, ADDR_W'(1));
               count_in   = count_ff - 1'b1;
            end
         end
         OP_PUSH_TAIL: begin
            if (full) begin
               res.error = 1'b1;
            end else begin
               req.addr  = ring_add(head_ff, ADDR_W'(count_ff));
               req.wr_en = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         OP_POP_TAIL: begin
            if (empty) begin
               res.error = 1'b1;
            end else begin
               req.addr   = ring_add(head_ff, ADDR_W'(count_ff - 1'b1));
               req.rd_en  = 1'b1;
               res.pop_ok = 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         OP_SWAP: begin
            if (count_ff >= CNT_W'(2)) begin
               head_in = ring_add(head_ff, ADDR_W'(count_ff >> 1));
            end
         end
         default: begin
         end
      endcase
      res.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      mem_req       = req;
      mem_req.wr_en = req.wr_en & accept;
      mem_req.rd_en = req.rd_en & accept;
      outcome       = res;
   end

endmodule

### tb/deque_with_half_rotate_tb.sv
`timescale 1ns / 1ps

module deque_with_half_rotate_tb;

   import dwhr_pkg::*;

   // The sender idles in roughly this many cycles out of a hundred.
   localparam int IDLE_PCT_DEFAULT = 36;
   // Absolute limit on the run time in ns, far beyond the slowest correct run.
   localparam int RUN_LIMIT_NS = 200_000;
   // The block answers in the cycle after a transfer; the extra tail cycles cover slack.
   localparam int TAIL_CYCLES = 4;
   // Function codes above swap are spare and must behave as a no-op.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
   localparam int DIR_ROWS = 24;

   // One result as seen on the rsp_ ports.
   typedef struct packed {
      logic [DATA_W-1:0] popped;
      logic              error;
      logic [SIZE_W-1:0] size_now;
      logic [MID_W-1:0]  middle;
   } deque_result_type;

   // One row of the directed table. When typed is set, want is the expected
   // result written out by hand; otherwise the predictor supplies it.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] value;
      logic              typed;
      deque_result_type  want;
   } stim_row_type;

   localparam deque_result_type FROM_MODEL = '0;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [FUNC_W-1:0]        req_func = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_popped_value;
   logic                     rsp_error;
   logic [SIZE_W-1:0]        rsp_size_now;
   logic [MID_W-1:0]         rsp_middle_position;

   // Predictor state: a ring of words, the head position and the fill count.
   logic [DATA_W-1:0] ring_words [DEPTH];
   int                ring_head;
   int                ring_count;

   // Results still owed by the block, oldest first.
   deque_result_type  owed_results [$];
   int                mismatch_count;
   int                idle_pct;
   stim_row_type      directed_rows [DIR_ROWS];

   deque_with_half_rotate u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_popped_value    (rsp_popped_value),
      .rsp_error           (rsp_error),
      .rsp_size_now        (rsp_size_now),
      .rsp_middle_position (rsp_middle_position)
   );

   always #1 clock = ~clock;

   // Applies one operation to the predictor and returns the result the block
   // must report for it. A pop from an empty ring and a push into a full ring
   // only raise the error flag; swap with fewer than two words does nothing.
   task automatic deque_apply(input logic [FUNC_W-1:0] func,
                              input logic [DATA_W-1:0] value,
                              output deque_result_type result);
      result = '0;
      case (func)
         OP_PUSH_HEAD: begin
            if (ring_count >= DEPTH) begin
               result.error = 1'b1;
            end else begin
               ring_head = (ring_head + DEPTH - 1) % DEPTH;
               ring_words[ring_head] = value;
               ring_count++;
            end
         end
         OP_POP_HEAD: begin
            if (ring_count == 0) begin
               result.error = 1'b1;
            end else begin
               result.popped = ring_words[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_count--;
            end
         end
         OP_PUSH_TAIL: begin
            if (ring_count >= DEPTH) begin
               result.error = 1'b1;
            end else begin
               ring_words[(ring_head + ring_count) % DEPTH] = value;
               ring_count++;
            end
         end
         OP_POP_TAIL: begin
            if (ring_count == 0) begin
               result.error = 1'b1;
            end else begin
               result.popped = ring_words[(ring_head + ring_count - 1) % DEPTH];
               ring_count--;
            end
         end
         OP_SWAP: begin
            // The word at index count/2 becomes the new head.
            if (ring_count >= 2) begin
               ring_head = (ring_head + ring_count / 2) % DEPTH;
            end
         end
         default: begin
         end
      endcase
      result.size_now = SIZE_W'(ring_count);
      result.middle   = (ring_count == 0) ? '0 : MID_W'(ring_count / 2 + 1);
   endtask

   // Presents one item and returns in the time step of the edge that accepts
   // it. Start is left high, so the caller either sends the next item or
   // lowers start in that same step; start is never assigned twice in a step.
   task automatic send_item(input logic [FUNC_W-1:0] func,
                            input logic [DATA_W-1:0] value,
                            input logic typed,
                            input deque_result_type typed_want);
      deque_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= func;
      req_value <= value;
      @(posedge clock);
      // Busy is sampled before the block updates it, so this is the value
      // that decided the transfer at this edge.
      while (busy) begin
         @(posedge clock);
      end
      // The predictor always advances, even when the row carries a typed
      // expectation, so that its state follows the block.
      deque_apply(func, value, predicted);
      owed_results.push_back(typed ? typed_want : predicted);
   endtask

   // Lowers start and holds the sender off until every owed result has come.
   task automatic wait_for_results();
      start <= 1'b0;
      while (owed_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Picks a function code: pushes with the given weight, otherwise mostly
   // pops, some swaps and now and then a spare code.
   function automatic logic [FUNC_W-1:0] pick_func(input int push_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         return ($urandom_range(1) != 0) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
      end
      roll = $urandom_range(99);
      if (roll < 40) begin
         return OP_POP_HEAD;
      end else if (roll < 80) begin
         return OP_POP_TAIL;
      end else if (roll < 95) begin
         return OP_SWAP;
      end
      return FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
   endfunction

   // Sends random items, either a fixed number of them or until the ring is
   // full. The push weight steers the fill level toward empty or full.
   task automatic run_random(input int n_items, input int push_pct, input bit until_full);
      int sent;
      sent = 0;
      while (until_full ? (ring_count < DEPTH) : (sent < n_items)) begin
         send_item(pick_func(push_pct), $urandom, 1'b0, FROM_MODEL);
         sent++;
      end
   endtask

   task automatic report_mismatch(input string field,
                                  input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   // Every result strobe is checked against the oldest owed result. The block
   // answers in the cycle after the transfer, so the expectation was queued at
   // an earlier edge than the one that samples the result.
   always @(posedge clock) begin
      deque_result_type want;
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            report_mismatch("unexpected result, popped_value", '0, rsp_popped_value);
         end else begin
            want = owed_results.pop_front();
            if (rsp_popped_value !== want.popped) begin
               report_mismatch("popped_value", want.popped, rsp_popped_value);
            end
            if (rsp_error !== want.error) begin
               report_mismatch("error", DATA_W'(want.error), DATA_W'(rsp_error));
            end
            if (rsp_size_now !== want.size_now) begin
               report_mismatch("size_now", DATA_W'(want.size_now), DATA_W'(rsp_size_now));
            end
            if (rsp_middle_position !== want.middle) begin
               report_mismatch("middle_position", DATA_W'(want.middle),
                               DATA_W'(rsp_middle_position));
            end
         end
      end
   end

   // Safety net in case the block stops answering or start is never taken.
   initial begin
      #(RUN_LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      // Directed rows start from an empty ring: errors on empty, swap and the
      // spare codes as no-ops, the extreme words, then a short mixed run that
      // walks the ring back to empty.
      directed_rows = '{
         '{OP_POP_HEAD,   32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 11'd0, 10'd0}},
         '{OP_POP_TAIL,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 11'd0, 10'd0}},
         '{OP_SWAP,       32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 11'd0, 10'd0}},
         '{FUNC_SPARE_LO, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b0, 11'd0, 10'd0}},
         '{FUNC_SPARE_HI, 32'h8765_4321, 1'b1, '{32'h0000_0000, 1'b0, 11'd0, 10'd0}},
         '{OP_PUSH_HEAD,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 11'd1, 10'd1}},
         '{OP_SWAP,       32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 11'd1, 10'd1}},
         '{OP_POP_TAIL,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b0, 11'd0, 10'd0}},
         '{OP_PUSH_TAIL,  32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 11'd1, 10'd1}},
         '{OP_POP_HEAD,   32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b0, 11'd0, 10'd0}},
         '{OP_PUSH_TAIL,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 11'd1, 10'd1}},
         '{OP_PUSH_HEAD,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 11'd2, 10'd2}},
         '{OP_PUSH_TAIL,  32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0, 11'd3, 10'd2}},
         '{OP_PUSH_HEAD,  32'h5555_5555, 1'b0, FROM_MODEL},
         '{OP_PUSH_TAIL,  32'hAAAA_AAAA, 1'b0, FROM_MODEL},
         '{OP_SWAP,       32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_SWAP,       32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_POP_HEAD,   32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_POP_TAIL,   32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_SWAP,       32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_POP_HEAD,   32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_POP_TAIL,   32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_POP_HEAD,   32'h0000_0000, 1'b0, FROM_MODEL},
         '{OP_POP_TAIL,   32'h0000_0000, 1'b0, FROM_MODEL}
      };
      ring_head      = 0;
      ring_count     = 0;
      mismatch_count = 0;
      idle_pct       = IDLE_PCT_DEFAULT;
      for (int i = 0; i < DEPTH; i++) begin
         ring_words[i] = '0;
      end

      // Reset is held from the start and released at a rising edge.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].func, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);
      end
      // The sender pauses here until every owed result has come back.
      wait_for_results();

      // Random traffic around an empty ring, so that failed pops are common.
      run_random(100, 45, 1'b0);

      // Fill toward full. The first stretch runs with no idle cycles at all,
      // so back-to-back transfers are exercised for a long time.
      idle_pct = 0;
      run_random(250, 95, 1'b0);
      idle_pct = IDLE_PCT_DEFAULT;
      run_random(0, 95, 1'b1);
      wait_for_results();

      // Hover around full: pushes into a full ring, swaps of the whole ring
      // and pops that make room again.
      run_random(60, 55, 1'b0);
      // Then drift back down with pops dominating.
      run_random(40, 30, 1'b0);

      // All stimulus is in; wait for the last results and a little beyond so
      // that any stray strobe is caught as well.
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && owed_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/dwhr_pkg.sv
rtl/core/dwhr_ram.sv
rtl/core/dwhr_ctrl.sv
rtl/core/deque_with_half_rotate.sv
tb/deque_with_half_rotate_tb.sv
